/* hw/rtl/rsvs_pkg.sv */
// ----------------------------------------------------------------------------
// rsvs_pkg
// Shared types and constants for the ring stack with valid-scan pop.
// ----------------------------------------------------------------------------
package rsvs_pkg;

  localparam int DEPTH_DEFAULT    = 16;
  localparam int PAYLOAD_BITS     = 32;
  localparam int TYPE_BITS        = 8;
  // Only types 1 to 3 are ever read back, so two bits of type are stored.
  localparam int STORED_TYPE_BITS = 2;

  localparam logic [TYPE_BITS-1:0] TYPE_VALID_LOW  = 8'd1;
  localparam logic [TYPE_BITS-1:0] TYPE_VALID_HIGH = 8'd3;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic [TYPE_BITS-1:0]    entry_type;
    logic [PAYLOAD_BITS-1:0] entry_payload;
  } req_t;

  typedef struct packed {
    logic                    found;
    logic [TYPE_BITS-1:0]    out_type;
    logic [PAYLOAD_BITS-1:0] out_payload;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  function automatic logic is_valid_type(logic [TYPE_BITS-1:0] t);
    return (t >= TYPE_VALID_LOW) && (t <= TYPE_VALID_HIGH);
  endfunction

endpackage

/* hw/rtl/ring_stack_valid_scan_pop.sv */
// ----------------------------------------------------------------------------
// ring_stack_valid_scan_pop
// Ring of slots with a head pointer; push at the head, pop the nearest
// valid entry behind it.
// ----------------------------------------------------------------------------
// A push request writes type and payload into the slot at the head and
// advances the head, and the next request may follow at once.
// A pop request passes these steps before its result is offered: it latches
// the valid marks rotated by the head, runs the priority search, which
// also reads the slot memory into its registered output, is held in the
// read state, and loads the output register. A pop that finds nothing
// skips the read state. The state sequence sets these steps; the memory's
// registered read latency is absorbed by the search step. A
// loaded result waits in the output register while the next request is
// taken; a pop reaching its load step waits until the previous result has
// gone. Valid marks live in flip-flops cleared by reset, so no clearing pass
// is needed after reset. Only types 1 to 3 count as valid; any other type
// pushed leaves the slot free. An empty pop returns found clear with zero
// type and payload and leaves the head where it was.
// ----------------------------------------------------------------------------
module ring_stack_valid_scan_pop
  import rsvs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int PTR_W = $clog2(DEPTH),
  localparam int MEM_W = STORED_TYPE_BITS + PAYLOAD_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  state_t           state;
  state_t           state_next;
  logic [PTR_W-1:0] head;
  logic [DEPTH-1:0] valid;
  logic             hit_q;

  logic             req_take;
  logic             do_push;
  logic             do_pop;
  logic             rsp_load;
  logic             scan_hit;
  logic [PTR_W-1:0] scan_pos;
  logic [PTR_W-1:0] head_inc;
  mem_ctl_t         mem_ctl;
  logic [MEM_W-1:0] mem_wr_data;
  logic [MEM_W-1:0] mem_rd_data;

  // Take requests only when nothing is in flight.
  assign req_stall = (state != ST_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign do_push   = req_take && (req.op == OP_PUSH);
  assign do_pop    = req_take && (req.op == OP_POP);
  assign rsp_load  = (state == ST_DONE) && (!rsp_valid || !rsp_stall);

  assign head_inc = (head == PTR_W'(DEPTH - 1)) ? '0 : head + PTR_W'(1);

  // Keep only the low type bits; a slot is read back only when its type was 1 to 3.
  assign mem_wr_data = {req.entry_type[STORED_TYPE_BITS-1:0], req.entry_payload};

  rsvs_scan #(
    .DEPTH (DEPTH)
  ) u_scan (
    .clk   (clk),
    .start (do_pop),
    .head  (head),
    .valid (valid),
    .hit   (scan_hit),
    .pos   (scan_pos)
  );

  rsvs_mem #(
    .DEPTH (DEPTH),
    .WIDTH (MEM_W)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (head),
    .wr_data (mem_wr_data),
    .rd_addr (scan_pos),
    .rd_data (mem_rd_data)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (do_pop) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        state_next = scan_hit ? ST_READ : ST_DONE;
      end
      ST_READ: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Memory strobes per state.
  always_comb begin
    mem_ctl = '0;
    unique case (state)
      ST_IDLE: begin
        mem_ctl.wr_en = do_push;
      end
      ST_SEARCH: begin
        mem_ctl.rd_en = scan_hit;
      end
      ST_READ, ST_DONE: begin
        mem_ctl = '0;
      end
      default: begin
        mem_ctl = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Head pointer and valid marks: advance on push, drop the found mark on pop.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      valid <= '0;
    end else if (do_push) begin
      head        <= head_inc;
      valid[head] <= is_valid_type(req.entry_type);
    end else if ((state == ST_SEARCH) && scan_hit) begin
      head            <= scan_pos;
      valid[scan_pos] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SEARCH) begin
      hit_q <= scan_hit;
    end
  end

  // Output register: hold while stalled, load a finished pop when free.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      if (hit_q) begin
        rsp.found       <= 1'b1;
        rsp.out_type    <= TYPE_BITS'(mem_rd_data[MEM_W-1:PAYLOAD_BITS]);
        rsp.out_payload <= mem_rd_data[PAYLOAD_BITS-1:0];
      end else begin
        rsp <= '0;
      end
    end
  end

  // A found entry always carries a valid type.
  a_found_type : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.found |->
      (rsp.out_type >= TYPE_VALID_LOW) && (rsp.out_type <= TYPE_VALID_HIGH))
    else $error("popped entry carries an invalid type");

  // An empty pop returns all zero.
  a_empty_zero : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.found |-> (rsp.out_type == '0) && (rsp.out_payload == '0))
    else $error("empty pop returned non-zero data");

  // A hit moves the head onto the found slot and frees it.
  a_hit_head : assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) && scan_hit |=>
      (head == $past(scan_pos)) && !valid[$past(scan_pos)])
    else $error("head or valid mark wrong after pop hit");

  // The search only reports a hit on a slot that is marked valid.
  a_hit_valid : assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) && scan_hit |-> valid[scan_pos])
    else $error("search hit on a free slot");

endmodule

/* hw/rtl/rsvs_mem.sv */
// ----------------------------------------------------------------------------
// rsvs_mem
// Slot memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module rsvs_mem
  import rsvs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int WIDTH = STORED_TYPE_BITS + PAYLOAD_BITS,
  localparam int PTR_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  mem_ctl_t         ctl,
  input  logic [PTR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [PTR_W-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/rsvs_scan.sv */
// ----------------------------------------------------------------------------
// rsvs_scan
// Rotated priority search: find the nearest valid slot below the head.
// ----------------------------------------------------------------------------
module rsvs_scan
  import rsvs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT,
  localparam int PTR_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             start,
  input  logic [PTR_W-1:0] head,
  input  logic [DEPTH-1:0] valid,
  output logic             hit,
  output logic [PTR_W-1:0] pos
);

  localparam logic [PTR_W:0] DEPTH_W = (PTR_W+1)'(DEPTH);

  logic [DEPTH-1:0] rot;
  logic [DEPTH-1:0] rot_next;
  logic [PTR_W-1:0] head_q;
  logic [PTR_W:0]   back [DEPTH];
  logic [PTR_W-1:0] off;
  logic [PTR_W:0]   step;

  // rot[k] is the slot k+1 places behind the head, wrapping round the ring.
  always_comb begin
    for (int k = 0; k < DEPTH; k++) begin
      if ({1'b0, head} >= (PTR_W+1)'(k + 1)) begin
        back[k] = {1'b0, head} - (PTR_W+1)'(k + 1);
      end else begin
        back[k] = {1'b0, head} + DEPTH_W - (PTR_W+1)'(k + 1);
      end
      rot_next[k] = valid[back[k][PTR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rot    <= rot_next;
      head_q <= head;
    end
  end

  // Lowest set bit of the rotated vector is the nearest valid slot.
  always_comb begin
    off = '0;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      if (rot[k]) begin
        off = PTR_W'(k);
      end
    end
  end

  assign hit  = |rot;
  assign step = {1'b0, off} + (PTR_W+1)'(1);

  always_comb begin
    if ({1'b0, head_q} >= step) begin
      pos = PTR_W'({1'b0, head_q} - step);
    end else begin
      pos = PTR_W'({1'b0, head_q} + DEPTH_W - step);
    end
  end

endmodule
